@@ hw/rtl/zctg_pkg.sv @@
// Shared types and constants for the zero-cross triac gate block.
package zctg_pkg;

    localparam int TIME_BITS = 48;
    localparam int CNT_W     = 32;
    localparam int MS_W      = 39;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int GLITCH_W  = 20;
    localparam int MAX_AGE_W = 24;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Event codes
    localparam logic [1:0] OP_EDGE  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE = 2'd2;

    localparam logic [GLITCH_W-1:0]  GLITCH_RESET  = 20'd4000;
    localparam logic [MAX_AGE_W-1:0] MAX_AGE_RESET = 24'd100000;

    typedef struct packed {
        logic [1:0]           op;
        logic [TIME_BITS-1:0] time_us;
        logic                 on;
    } zctg_in_t;

    typedef struct packed {
        logic             gate;
        logic             active;
        logic             running;
        logic             sig_live;
        logic [CNT_W-1:0] edge_total;
        logic [CNT_W-1:0] rejected_count;
        logic [CNT_W-1:0] gap_count;
        logic [CNT_W-1:0] period_last;
        logic [CNT_W-1:0] period_min;
        logic [CNT_W-1:0] period_max;
        logic [MS_W-1:0]  edge_time_ms;
    } zctg_out_t;

endpackage

@@ hw/rtl/zctg_ms_div.sv @@
// Pipelined divide-by-1000 of the last edge time, carrying the status record alongside.
module zctg_ms_div import zctg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [TIME_BITS-1:0] in_time,
    input  zctg_out_t            in_info,
    output logic                 out_valid,
    input  logic                 out_ready,
    output zctg_out_t            out_info
);

    localparam int DIGIT_W = 16;
    localparam int DIGITS  = (TIME_BITS + DIGIT_W - 1) / DIGIT_W;
    localparam int DIV_W   = DIGITS * DIGIT_W;
    localparam int STAGES  = 2 * DIGITS;
    localparam int REM_W   = 10;
    localparam int PART_W  = REM_W + DIGIT_W;
    localparam int PROD_W  = PART_W + DIGIT_W;
    localparam int RECIP_SHIFT = 25;
    localparam logic [DIGIT_W-1:0] RECIP   = 16'd33554;
    localparam logic [PART_W-1:0]  DIVISOR = 26'd1000;

    typedef struct packed {
        logic [DIV_W-1:0]   num;
        logic [DIV_W-1:0]   quo;
        logic [REM_W-1:0]   rem;
        logic [PART_W-1:0]  part;
        logic [DIGIT_W-1:0] q_est;
        zctg_out_t          info;
    } div_stage_t;

    div_stage_t  st_reg  [STAGES];
    div_stage_t  st_next [STAGES];
    div_stage_t  src     [STAGES];
    logic        vld_reg [STAGES];
    logic        src_vld [STAGES];
    logic        rdy     [STAGES+1];
    div_stage_t  entry;
    logic [63:0] quo_ext;

    always_comb begin
        entry       = '0;
        entry.num   = DIV_W'(in_time);
        entry.info  = in_info;
    end

    assign rdy[STAGES] = out_ready;
    assign in_ready    = rdy[0];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam int HI = DIV_W - 1 - DIGIT_W * (s / 2);

        if (s == 0) begin : g_first
            assign src[s]     = entry;
            assign src_vld[s] = in_valid;
        end else begin : g_chain
            assign src[s]     = st_reg[s-1];
            assign src_vld[s] = vld_reg[s-1];
        end

        assign rdy[s] = !vld_reg[s] || rdy[s+1];

        if ((s % 2) == 0) begin : g_est
            // Estimate the digit quotient by reciprocal multiply; low by at most one
            logic [PART_W-1:0] part;
            logic [PROD_W-1:0] prod;
            always_comb begin
                part          = {src[s].rem, src[s].num[HI -: DIGIT_W]};
                prod          = PROD_W'(part) * PROD_W'(RECIP);
                st_next[s]       = src[s];
                st_next[s].part  = part;
                st_next[s].q_est = prod[RECIP_SHIFT +: DIGIT_W];
            end
        end else begin : g_fix
            logic [PART_W-1:0]  rem_raw;
            logic               bump;
            logic [DIGIT_W-1:0] q_digit;
            always_comb begin
                rem_raw = src[s].part - PART_W'(src[s].q_est) * DIVISOR;
                bump    = rem_raw >= DIVISOR;
                q_digit = src[s].q_est + DIGIT_W'(bump);
                st_next[s] = src[s];
                st_next[s].quo[HI -: DIGIT_W] = q_digit;
                st_next[s].rem = bump ? REM_W'(rem_raw - DIVISOR) : REM_W'(rem_raw);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (rdy[s]) begin
                vld_reg[s] <= src_vld[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[s] && src_vld[s]) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign quo_ext   = 64'(st_reg[STAGES-1].quo);

    always_comb begin
        out_info              = st_reg[STAGES-1].info;
        out_info.edge_time_ms = quo_ext[MS_W-1:0];
    end

endmodule

@@ hw/rtl/zero_cross_triac_gate.sv @@
// Channel   Ports                      Direction  Payload
// --------  -------------------------  ---------  -------------------------------
// event     s_valid s_ready s_data     in         op, time_us, on (zctg_in_t)
// status    m_valid m_ready m_data     out        gate, flags, counters, periods
// config    cfg_we cfg_index cfg_data  in         enable, glitch, max age
//
// One event per cycle sustained while m_ready does not stall; m_valid rises once the transaction
// has passed the input register and the divide by 1000 (an estimate and a correction stage per digit).
// Event state updates in the cycle the event leaves the input register.
// aresetn is synchronous, active low; it clears state and restores register defaults.
// A stalled m_ready backs up stage by stage; empty stages keep taking transactions.
module zero_cross_triac_gate import zctg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  zctg_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output zctg_out_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    logic                 enable_reg;
    logic [GLITCH_W-1:0]  glitch_reg;
    logic [MAX_AGE_W-1:0] max_age_reg;

    zctg_in_t             in_reg;
    logic                 in_vld_reg;

    logic                 request_reg,   request_next;
    logic                 applied_reg,   applied_next;
    logic [TIME_BITS-1:0] last_edge_reg, last_edge_next;
    logic [CNT_W-1:0]     edges_reg,     edges_next;
    logic [CNT_W-1:0]     rejects_reg,   rejects_next;
    logic [CNT_W-1:0]     gaps_reg,      gaps_next;
    logic [CNT_W-1:0]     recent_reg,    recent_next;
    logic [CNT_W-1:0]     shortest_reg,  shortest_next;
    logic [CNT_W-1:0]     longest_reg,   longest_next;

    logic                 div_ready;
    logic                 adv;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] diff;
    logic                 have_prev;
    logic                 too_soon;
    logic                 take;
    logic                 present;
    logic [CNT_W-1:0]     period;
    zctg_out_t            info;

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            glitch_reg  <= GLITCH_RESET;
            max_age_reg <= MAX_AGE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ENABLE:  enable_reg  <= cfg_data[0];
                CFG_GLITCH:  glitch_reg  <= cfg_data[GLITCH_W-1:0];
                CFG_MAX_AGE: max_age_reg <= cfg_data[MAX_AGE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    assign s_ready = !in_vld_reg || div_ready;
    assign adv     = in_vld_reg && div_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Event evaluation
    assign now       = in_reg.time_us;
    assign diff      = now - last_edge_reg;
    assign have_prev = last_edge_reg != '0;
    assign too_soon  = have_prev &&
                       (now <= last_edge_reg || diff < TIME_BITS'(glitch_reg));
    assign period    = (diff > TIME_BITS'(CNT_MAX)) ? CNT_MAX : diff[CNT_W-1:0];

    always_comb begin
        request_next  = request_reg;
        applied_next  = applied_reg;
        last_edge_next = last_edge_reg;
        edges_next    = edges_reg;
        rejects_next  = rejects_reg;
        gaps_next     = gaps_reg;
        recent_next   = recent_reg;
        shortest_next = shortest_reg;
        longest_next  = longest_reg;
        take          = 1'b0;
        case (in_reg.op)
            OP_EDGE: begin
                if (enable_reg) begin
                    if (too_soon) begin
                        rejects_next = sat_inc(rejects_reg);
                    end else begin
                        take = 1'b1;
                        if (have_prev) begin
                            if (diff > TIME_BITS'(max_age_reg)) begin
                                gaps_next = sat_inc(gaps_reg);
                            end
                            recent_next = period;
                            if (shortest_reg == '0 || period < shortest_reg) begin
                                shortest_next = period;
                            end
                            if (period > longest_reg) begin
                                longest_next = period;
                            end
                        end
                        last_edge_next = now;
                        edges_next     = sat_inc(edges_reg);
                        applied_next   = request_reg;
                    end
                end
            end
            OP_SET: begin
                request_next = in_reg.on && enable_reg;
                if (!request_next) begin
                    applied_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Signal presence after the event: age is zero when this edge was just taken, else within max age
    assign present = take ? (now != '0)
                          : (have_prev && now >= last_edge_reg &&
                             diff <= TIME_BITS'(max_age_reg));

    always_comb begin
        info                = '0;
        info.gate           = applied_next;
        info.active         = enable_reg && request_next;
        info.running        = enable_reg && applied_next && present;
        info.sig_live       = present;
        info.edge_total     = edges_next;
        info.rejected_count = rejects_next;
        info.gap_count      = gaps_next;
        info.period_last    = recent_next;
        info.period_min     = shortest_next;
        info.period_max     = longest_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            request_reg   <= 1'b0;
            applied_reg   <= 1'b0;
            last_edge_reg <= '0;
            edges_reg     <= '0;
            rejects_reg   <= '0;
            gaps_reg      <= '0;
            recent_reg    <= '0;
            shortest_reg  <= '0;
            longest_reg   <= '0;
        end else if (adv) begin
            request_reg   <= request_next;
            applied_reg   <= applied_next;
            last_edge_reg <= last_edge_next;
            edges_reg     <= edges_next;
            rejects_reg   <= rejects_next;
            gaps_reg      <= gaps_next;
            recent_reg    <= recent_next;
            shortest_reg  <= shortest_next;
            longest_reg   <= longest_next;
        end
    end

    zctg_ms_div u_ms_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_vld_reg),
        .in_ready  (div_ready),
        .in_time   (last_edge_next),
        .in_info   (info),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_info  (m_data)
    );

`ifndef NO_ASSERTIONS
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        shortest_reg != '0 |-> shortest_reg <= longest_reg)
        else $error("min period above max period");

    a_recent_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        recent_reg != '0 |-> (shortest_reg <= recent_reg && recent_reg <= longest_reg))
        else $error("last period outside min/max range");

    a_applied_needs_request: assert property (@(posedge aclk) disable iff (!aresetn)
        applied_reg |-> request_reg)
        else $error("gate applied without a pending on-request");

    a_state_holds_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(edges_reg) && $stable(rejects_reg) && $stable(last_edge_reg)))
        else $error("edge state changed without an event");
`endif

endmodule
